// ----- hw/rtl/instruction_decode_and_immediate_macros.svh -----
// Assertion macros shared by the instruction decode RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef INSTRUCTION_DECODE_AND_IMMEDIATE_MACROS_SVH
`define INSTRUCTION_DECODE_AND_IMMEDIATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("instruction decode: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("instruction decode: next-cycle check failed");

`endif

// ----- hw/rtl/idi_pkg.sv -----
// Shared opcodes, codes and the decoded-word struct for the instruction decoder.
// Depends on nothing; used by idi_decode and instruction_decode_and_immediate.
package idi_pkg;

    localparam int unsigned XLEN = 32;

    localparam logic [6:0] OPC_R     = 7'h33;
    localparam logic [6:0] OPC_I     = 7'h13;
    localparam logic [6:0] OPC_S     = 7'h23;
    localparam logic [6:0] OPC_B     = 7'h63;
    localparam logic [6:0] OPC_LOAD  = 7'h03;
    localparam logic [6:0] OPC_JAL   = 7'h6F;
    localparam logic [6:0] OPC_JALR  = 7'h67;
    localparam logic [6:0] OPC_LUI   = 7'h37;
    localparam logic [6:0] OPC_AUIPC = 7'h17;
    localparam logic [6:0] OPC_SYS   = 7'h73;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [2:0] ALU_MEXT   = 3'd0;
    localparam logic [2:0] ALU_R      = 3'd1;
    localparam logic [2:0] ALU_I      = 3'd2;
    localparam logic [2:0] ALU_BRANCH = 3'd3;
    localparam logic [2:0] ALU_LUI    = 3'd4;
    localparam logic [2:0] ALU_AUIPC  = 3'd5;
    localparam logic [2:0] ALU_MEM    = 3'd6;

    typedef struct packed {
        logic [XLEN-1:0] immediate;
        logic            reg_write;
        logic            alu_source_imm;
        logic [1:0]      mem_op;
        logic            branch;
        logic            jump;
        logic            is_auipc;
        logic            is_lui;
        logic [2:0]      alu_class;
        logic [1:0]      access_size;
        logic            sign_extend;
        logic            halt;
    } dec_t;

endpackage

// ----- hw/rtl/idi_decode.sv -----
// Combinational decode of one RV32IM instruction word into control and immediate.
// Depends on idi_pkg for opcodes, codes and the dec_t struct.
module idi_decode
(
    input  logic [idi_pkg::XLEN-1:0] instruction,
    output idi_pkg::dec_t            dec
);

    logic [idi_pkg::XLEN-1:0] w;

    assign w = instruction;

    always_comb
    begin
        dec             = '0;
        dec.alu_class   = idi_pkg::ALU_MEM;
        // Size and extension come straight from funct3 whatever the opcode.
        dec.access_size = w[13:12];
        dec.sign_extend = ~w[14];
        case (w[6:0])
            idi_pkg::OPC_R:
            begin
                dec.reg_write = 1'b1;
                dec.alu_class = w[25] ? idi_pkg::ALU_MEXT : idi_pkg::ALU_R;
            end
            idi_pkg::OPC_I:
            begin
                dec.immediate      = {{20{w[31]}}, w[31:20]};
                dec.reg_write      = 1'b1;
                dec.alu_source_imm = 1'b1;
                dec.alu_class      = idi_pkg::ALU_I;
            end
            idi_pkg::OPC_LOAD:
            begin
                dec.immediate      = {{20{w[31]}}, w[31:20]};
                dec.reg_write      = 1'b1;
                dec.alu_source_imm = 1'b1;
                dec.mem_op         = idi_pkg::MEM_LOAD;
            end
            idi_pkg::OPC_JALR:
            begin
                dec.immediate = {{20{w[31]}}, w[31:20]};
                dec.reg_write = 1'b1;
                dec.branch    = 1'b1;
                dec.alu_class = idi_pkg::ALU_BRANCH;
            end
            idi_pkg::OPC_S:
            begin
                dec.immediate      = {{20{w[31]}}, w[31:25], w[11:7]};
                dec.alu_source_imm = 1'b1;
                dec.mem_op         = idi_pkg::MEM_STORE;
            end
            idi_pkg::OPC_B:
            begin
                dec.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                dec.branch    = 1'b1;
                dec.alu_class = idi_pkg::ALU_BRANCH;
            end
            idi_pkg::OPC_JAL:
            begin
                dec.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                dec.reg_write = 1'b1;
                dec.branch    = 1'b1;
                dec.jump      = 1'b1;
                dec.alu_class = idi_pkg::ALU_BRANCH;
            end
            idi_pkg::OPC_LUI:
            begin
                dec.immediate      = {w[31:12], 12'h000};
                dec.reg_write      = 1'b1;
                dec.alu_source_imm = 1'b1;
                dec.is_lui         = 1'b1;
                dec.alu_class      = idi_pkg::ALU_LUI;
            end
            idi_pkg::OPC_AUIPC:
            begin
                dec.immediate      = {w[31:12], 12'h000};
                dec.reg_write      = 1'b1;
                dec.alu_source_imm = 1'b1;
                dec.is_auipc       = 1'b1;
                dec.alu_class      = idi_pkg::ALU_AUIPC;
            end
            idi_pkg::OPC_SYS:
            begin
                dec.halt = 1'b1;
            end
            default:
            begin
                dec.halt = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/instruction_decode_and_immediate.sv -----
// RV32IM instruction decoder with immediate generation. Each instruction word
// accepted on the input is registered, decoded in one pass and held in a result
// register, and a new word is taken every
// cycle while the output is not stalled. The input stall follows the output
// stall only when both registers are full; a waiting result never blocks the
// input register from filling.
// Depends on idi_pkg, idi_decode and instruction_decode_and_immediate_macros.svh.
`include "instruction_decode_and_immediate_macros.svh"

module instruction_decode_and_immediate
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [idi_pkg::XLEN-1:0] instruction,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [idi_pkg::XLEN-1:0] immediate,
    output logic                     reg_write,
    output logic                     alu_source_imm,
    output logic [1:0]               mem_op,
    output logic                     branch,
    output logic                     jump,
    output logic                     is_auipc,
    output logic                     is_lui,
    output logic [2:0]               alu_class,
    output logic [1:0]               access_size,
    output logic                     sign_extend,
    output logic                     halt
);

    logic                     in_valid_reg;
    logic [idi_pkg::XLEN-1:0] instr_reg;
    logic                     out_valid_reg;
    idi_pkg::dec_t            result_reg;
    idi_pkg::dec_t            dec_next;
    logic                     adv_out;
    logic                     adv_in;
    logic                     in_take;

    // A stage may load when it is empty or its contents move on this cycle.
    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv_in   = !in_valid_reg || adv_out;
    assign in_stall = !adv_in;
    assign in_take  = in_valid && adv_in;

    idi_decode u_decode
    (
        .instruction (instr_reg),
        .dec         (dec_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_in)
            begin
                in_valid_reg <= in_valid;
            end
            if (adv_out)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            instr_reg <= instruction;
        end
        if (adv_out && in_valid_reg)
        begin
            result_reg <= dec_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign immediate      = result_reg.immediate;
    assign reg_write      = result_reg.reg_write;
    assign alu_source_imm = result_reg.alu_source_imm;
    assign mem_op         = result_reg.mem_op;
    assign branch         = result_reg.branch;
    assign jump           = result_reg.jump;
    assign is_auipc       = result_reg.is_auipc;
    assign is_lui         = result_reg.is_lui;
    assign alu_class      = result_reg.alu_class;
    assign access_size    = result_reg.access_size;
    assign sign_extend    = result_reg.sign_extend;
    assign halt           = result_reg.halt;

    // A halt word carries no immediate and touches neither registers nor memory.
    `IDI_ASSERT_NOW(a_halt_quiet, clk, rst_n, out_valid_reg && result_reg.halt,
        !result_reg.reg_write && result_reg.mem_op == idi_pkg::MEM_NONE
        && result_reg.immediate == '0)
    // Loads and stores always form their address from the immediate.
    `IDI_ASSERT_NOW(a_mem_uses_imm, clk, rst_n,
        out_valid_reg && result_reg.mem_op != idi_pkg::MEM_NONE,
        result_reg.alu_source_imm && result_reg.alu_class == idi_pkg::ALU_MEM)
    // A jump is also a branch that writes the link register.
    `IDI_ASSERT_NOW(a_jump_links, clk, rst_n, out_valid_reg && result_reg.jump,
        result_reg.branch && result_reg.reg_write && result_reg.immediate[0] == 1'b0)
    // An accepted word always lands in the input register.
    `IDI_ASSERT_NEXT(a_take_fills, clk, rst_n, in_valid && !in_stall, in_valid_reg)
    // A full input register with a free output moves into the result register.
    `IDI_ASSERT_NEXT(a_input_drains, clk, rst_n, in_valid_reg && adv_out, out_valid_reg)

endmodule
